// File: sv/qrm_pkg.sv
// Shared widths, lane order and stage payload types for the quaternion to
// rotation matrix pipeline. No dependencies.
package qrm_pkg;

	localparam int unsigned IN_W  = 16;   // Q1.14 input component
	localparam int unsigned OUT_W = 16;   // Q1.14 matrix entry
	localparam int unsigned PRD_W = 32;   // signed 16x16 product
	localparam int unsigned SQ_W  = 31;   // square magnitude, at most 2^30
	localparam int unsigned N_W   = 33;   // sum of four squares, at most 2^32
	localparam int unsigned MAG_W = 33;   // scaled numerator magnitude, never above N
	localparam int unsigned Q_W   = 16;   // quotient bits of floor(mag * 2^15 / N)
	localparam int unsigned LANES = 9;

	localparam int unsigned PREP_STAGES = 3;
	localparam int unsigned LATENCY     = PREP_STAGES + Q_W + 1;

	localparam logic signed [OUT_W-1:0] ONE_Q14 = OUT_W'(16384);
	localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Lane order is the row order of the matrix.
	localparam int unsigned L_M00 = 0;
	localparam int unsigned L_M01 = 1;
	localparam int unsigned L_M02 = 2;
	localparam int unsigned L_M10 = 3;
	localparam int unsigned L_M11 = 4;
	localparam int unsigned L_M12 = 5;
	localparam int unsigned L_M20 = 6;
	localparam int unsigned L_M21 = 7;
	localparam int unsigned L_M22 = 8;

	typedef struct packed {
		logic [LANES-1:0][MAG_W-1:0] mag;
		logic [LANES-1:0]            neg;
		logic [N_W-1:0]              n;
		logic                        zero;
	} div_in_t;

	typedef struct packed {
		logic [LANES-1:0][Q_W-1:0] quo;
		logic [LANES-1:0]          neg;
		logic                      zero;
	} div_out_t;

	typedef logic signed [LANES-1:0][OUT_W-1:0] mat_t;

endpackage

// File: sv/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, Q1.14 in and out. Takes one quaternion
// in every cycle: busy is always low and start alone accepts an item. Each
// result appears on m00..m22 and zero_norm with done high for one cycle,
// after three stages of products and sums, sixteen stages of a restoring
// divider that produces one quotient bit per stage for all nine entries
// against the shared norm, and one rounding stage. The quaternion need not
// be unit length; an all-zero input gives the identity with zero_norm set.
// Uses qrm_pkg, qrm_prep, qrm_divider, qrm_out.
module quaternion_to_rotation_matrix (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [qrm_pkg::IN_W-1:0]  qx,
	input  logic signed [qrm_pkg::IN_W-1:0]  qy,
	input  logic signed [qrm_pkg::IN_W-1:0]  qz,
	input  logic signed [qrm_pkg::IN_W-1:0]  qw,
	output logic                            done,
	output logic signed [qrm_pkg::OUT_W-1:0] m00,
	output logic signed [qrm_pkg::OUT_W-1:0] m01,
	output logic signed [qrm_pkg::OUT_W-1:0] m02,
	output logic signed [qrm_pkg::OUT_W-1:0] m10,
	output logic signed [qrm_pkg::OUT_W-1:0] m11,
	output logic signed [qrm_pkg::OUT_W-1:0] m12,
	output logic signed [qrm_pkg::OUT_W-1:0] m20,
	output logic signed [qrm_pkg::OUT_W-1:0] m21,
	output logic signed [qrm_pkg::OUT_W-1:0] m22,
	output logic                            zero_norm
);
	import qrm_pkg::*;

	logic     prep_vld;
	div_in_t  prep_d;
	logic     div_vld;
	div_out_t div_d;
	mat_t     mat;

	// Nothing downstream can stall, so the pipeline never holds off an item.
	assign busy = 1'b0;

	qrm_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.qx      (qx),
		.qy      (qy),
		.qz      (qz),
		.qw      (qw),
		.out_vld (prep_vld),
		.out_d   (prep_d)
	);

	qrm_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (prep_vld),
		.in_d    (prep_d),
		.out_vld (div_vld),
		.out_d   (div_d)
	);

	qrm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (div_vld),
		.in_d      (div_d),
		.out_vld   (done),
		.mat       (mat),
		.zero_norm (zero_norm)
	);

	assign m00 = mat[L_M00];
	assign m01 = mat[L_M01];
	assign m02 = mat[L_M02];
	assign m10 = mat[L_M10];
	assign m11 = mat[L_M11];
	assign m12 = mat[L_M12];
	assign m20 = mat[L_M20];
	assign m21 = mat[L_M21];
	assign m22 = mat[L_M22];

	logic signed [OUT_W+1:0] trace;
	assign trace = (OUT_W+2)'(m00) + (OUT_W+2)'(m11) + (OUT_W+2)'(m22);

	// A zero quaternion must come out as the identity.
	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_norm |-> m00 == ONE_Q14 && m11 == ONE_Q14 && m22 == ONE_Q14
			&& m01 == '0 && m02 == '0 && m10 == '0 && m12 == '0 && m20 == '0 && m21 == '0)
		else $error("zero quaternion did not give the identity");

	// Every entry of a rotation lies within [-1, 1].
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !zero_norm |-> m00 >= -ONE_Q14 && m00 <= ONE_Q14 && m01 >= -ONE_Q14
			&& m01 <= ONE_Q14 && m02 >= -ONE_Q14 && m02 <= ONE_Q14 && m10 >= -ONE_Q14
			&& m10 <= ONE_Q14 && m11 >= -ONE_Q14 && m11 <= ONE_Q14 && m12 >= -ONE_Q14
			&& m12 <= ONE_Q14 && m20 >= -ONE_Q14 && m20 <= ONE_Q14 && m21 >= -ONE_Q14
			&& m21 <= ONE_Q14 && m22 >= -ONE_Q14 && m22 <= ONE_Q14)
		else $error("matrix entry outside [-1, 1]");

	// Trace of a rotation is 4w^2/N - 1, in [-1, 3], plus rounding.
	a_trace_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !zero_norm |-> trace >= -(OUT_W+2)'(16387) && trace <= (OUT_W+2)'(49155))
		else $error("matrix trace outside [-1, 3]");

endmodule

// File: sv/qrm_prep.sv
// Front end: products, sum of squares and the nine numerator magnitudes.
// Three register stages; uses qrm_pkg.
module qrm_prep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic signed [qrm_pkg::IN_W-1:0] qx,
	input  logic signed [qrm_pkg::IN_W-1:0] qy,
	input  logic signed [qrm_pkg::IN_W-1:0] qz,
	input  logic signed [qrm_pkg::IN_W-1:0] qw,
	output logic                        out_vld,
	output qrm_pkg::div_in_t            out_d
);
	import qrm_pkg::*;

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [PRD_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PRD_W-1:0] xy_s1, xz_s1, xw_s1, yz_s1, yw_s1, zw_s1;

	logic [N_W-1:0]          n_s2;
	logic [SQ_W:0]           pyz_s2, pxz_s2, pxy_s2;
	logic signed [PRD_W:0]   o01_s2, o02_s2, o10_s2, o12_s2, o20_s2, o21_s2;

	div_in_t                 d_s3;

	logic signed [PRD_W:0]   off_sum [6];
	logic [SQ_W:0]           pair_sum [3];
	logic [MAG_W-1:0]        off_mag [6];
	logic [5:0]              off_neg;
	logic [MAG_W-1:0]        diag_mag [3];
	logic [2:0]              diag_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: ten products.
	always_ff @(posedge clk) begin
		xx_s1 <= PRD_W'(qx) * PRD_W'(qx);
		yy_s1 <= PRD_W'(qy) * PRD_W'(qy);
		zz_s1 <= PRD_W'(qz) * PRD_W'(qz);
		ww_s1 <= PRD_W'(qw) * PRD_W'(qw);
		xy_s1 <= PRD_W'(qx) * PRD_W'(qy);
		xz_s1 <= PRD_W'(qx) * PRD_W'(qz);
		xw_s1 <= PRD_W'(qx) * PRD_W'(qw);
		yz_s1 <= PRD_W'(qy) * PRD_W'(qz);
		yw_s1 <= PRD_W'(qy) * PRD_W'(qw);
		zw_s1 <= PRD_W'(qz) * PRD_W'(qw);
	end

	// Stage 2: norm, diagonal pair sums, off-diagonal sums.
	always_ff @(posedge clk) begin
		n_s2   <= N_W'(xx_s1[SQ_W-1:0]) + N_W'(yy_s1[SQ_W-1:0])
			+ N_W'(zz_s1[SQ_W-1:0]) + N_W'(ww_s1[SQ_W-1:0]);
		pyz_s2 <= (SQ_W+1)'(yy_s1[SQ_W-1:0]) + (SQ_W+1)'(zz_s1[SQ_W-1:0]);
		pxz_s2 <= (SQ_W+1)'(xx_s1[SQ_W-1:0]) + (SQ_W+1)'(zz_s1[SQ_W-1:0]);
		pxy_s2 <= (SQ_W+1)'(xx_s1[SQ_W-1:0]) + (SQ_W+1)'(yy_s1[SQ_W-1:0]);
		o01_s2 <= (PRD_W+1)'(xy_s1) + (PRD_W+1)'(zw_s1);
		o02_s2 <= (PRD_W+1)'(xz_s1) - (PRD_W+1)'(yw_s1);
		o10_s2 <= (PRD_W+1)'(xy_s1) - (PRD_W+1)'(zw_s1);
		o12_s2 <= (PRD_W+1)'(yz_s1) + (PRD_W+1)'(xw_s1);
		o20_s2 <= (PRD_W+1)'(xz_s1) + (PRD_W+1)'(yw_s1);
		o21_s2 <= (PRD_W+1)'(yz_s1) - (PRD_W+1)'(xw_s1);
	end

	// Stage 3: sign and magnitude of each numerator, scaled so that mag <= N.
	// Off-diagonal: mag = 2|sum|. Diagonal: mag = |N - 2(a + b)|.
	always_comb begin
		off_sum[0]  = o01_s2;
		off_sum[1]  = o02_s2;
		off_sum[2]  = o10_s2;
		off_sum[3]  = o12_s2;
		off_sum[4]  = o20_s2;
		off_sum[5]  = o21_s2;
		pair_sum[0] = pyz_s2;
		pair_sum[1] = pxz_s2;
		pair_sum[2] = pxy_s2;
	end

	for (genvar i = 0; i < 6; i++) begin : g_off
		logic signed [PRD_W:0] abs_v;
		assign abs_v      = off_sum[i][PRD_W] ? -off_sum[i] : off_sum[i];
		assign off_mag[i] = {abs_v[PRD_W-1:0], 1'b0};
		assign off_neg[i] = off_sum[i][PRD_W];
	end

	for (genvar i = 0; i < 3; i++) begin : g_diag
		logic signed [N_W:0] diff;
		logic signed [N_W:0] diff_n;
		assign diff        = $signed({1'b0, n_s2}) - $signed({1'b0, pair_sum[i], 1'b0});
		assign diff_n      = -diff;
		assign diag_mag[i] = diff[N_W] ? diff_n[MAG_W-1:0] : diff[MAG_W-1:0];
		assign diag_neg[i] = diff[N_W];
	end

	always_ff @(posedge clk) begin
		d_s3.mag[L_M00] <= diag_mag[0];
		d_s3.mag[L_M01] <= off_mag[0];
		d_s3.mag[L_M02] <= off_mag[1];
		d_s3.mag[L_M10] <= off_mag[2];
		d_s3.mag[L_M11] <= diag_mag[1];
		d_s3.mag[L_M12] <= off_mag[3];
		d_s3.mag[L_M20] <= off_mag[4];
		d_s3.mag[L_M21] <= off_mag[5];
		d_s3.mag[L_M22] <= diag_mag[2];
		d_s3.neg[L_M00] <= diag_neg[0];
		d_s3.neg[L_M01] <= off_neg[0];
		d_s3.neg[L_M02] <= off_neg[1];
		d_s3.neg[L_M10] <= off_neg[2];
		d_s3.neg[L_M11] <= diag_neg[1];
		d_s3.neg[L_M12] <= off_neg[3];
		d_s3.neg[L_M20] <= off_neg[4];
		d_s3.neg[L_M21] <= off_neg[5];
		d_s3.neg[L_M22] <= diag_neg[2];
		d_s3.n          <= n_s2;
		d_s3.zero       <= (n_s2 == '0);
	end

	assign out_vld = vld_s3;
	assign out_d   = d_s3;

endmodule

// File: sv/qrm_divider.sv
// Nine-lane pipelined restoring divider: one quotient bit per stage, all
// lanes share the divisor N. Uses qrm_pkg.
module qrm_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  qrm_pkg::div_in_t  in_d,
	output logic              out_vld,
	output qrm_pkg::div_out_t out_d
);
	import qrm_pkg::*;

	logic [Q_W-1:0]                vld_s;
	logic [Q_W-1:0]                zero_s;
	logic [N_W-1:0]                n_s   [Q_W];
	logic [LANES-1:0][MAG_W-1:0]   rem_s [Q_W];
	logic [LANES-1:0][Q_W-1:0]     quo_s [Q_W];
	logic [LANES-1:0]              neg_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic                        vld_in;
		logic                        zero_in;
		logic [N_W-1:0]              n_in;
		logic [LANES-1:0][MAG_W-1:0] rem_in;
		logic [LANES-1:0][Q_W-1:0]   quo_in;
		logic [LANES-1:0]            neg_in;
		logic [LANES-1:0][MAG_W-1:0] rem_nx;
		logic [LANES-1:0]            bit_nx;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign zero_in = in_d.zero;
			assign n_in    = in_d.n;
			assign rem_in  = in_d.mag;
			assign quo_in  = '0;
			assign neg_in  = in_d.neg;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign zero_in = zero_s[k-1];
			assign n_in    = n_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign neg_in  = neg_s[k-1];
		end

		// The first step takes mag as is (mag <= N), later ones double the remainder.
		always_comb begin
			logic [MAG_W:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = (k == 0) ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
				if (trial >= {1'b0, n_in}) begin
					bit_nx[l] = 1'b1;
					rem_nx[l] = MAG_W'(trial - {1'b0, n_in});
				end else begin
					bit_nx[l] = 1'b0;
					rem_nx[l] = trial[MAG_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			zero_s[k] <= zero_in;
			n_s[k]    <= n_in;
			rem_s[k]  <= rem_nx;
			neg_s[k]  <= neg_in;
			for (int l = 0; l < LANES; l++) begin
				quo_s[k][l] <= {quo_in[l][Q_W-2:0], bit_nx[l]};
			end
		end
	end

	assign out_vld    = vld_s[Q_W-1];
	assign out_d.quo  = quo_s[Q_W-1];
	assign out_d.neg  = neg_s[Q_W-1];
	assign out_d.zero = zero_s[Q_W-1];

endmodule

// File: sv/qrm_out.sv
// Output stage: round the half-step quotient, apply sign, saturate, and
// substitute the identity for a zero quaternion. Uses qrm_pkg.
module qrm_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  qrm_pkg::div_out_t in_d,
	output logic              out_vld,
	output qrm_pkg::mat_t     mat,
	output logic              zero_norm
);
	import qrm_pkg::*;

	logic  vld_s20;
	logic  zero_s20;
	mat_t  mat_s20;
	mat_t  mat_nx;

	// quo = floor(2 * ratio); (quo + 1) >> 1 rounds ties away from zero.
	always_comb begin
		logic [Q_W:0]          rnd;
		logic signed [Q_W+1:0] sval;
		for (int l = 0; l < LANES; l++) begin
			rnd  = ({1'b0, in_d.quo[l]} + (Q_W+1)'(1)) >> 1;
			sval = in_d.neg[l] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
			if (in_d.zero) begin
				mat_nx[l] = (l == L_M00 || l == L_M11 || l == L_M22) ? ONE_Q14 : '0;
			end else if (sval > (Q_W+2)'(SAT_MAX)) begin
				mat_nx[l] = SAT_MAX;
			end else if (sval < (Q_W+2)'(SAT_MIN)) begin
				mat_nx[l] = SAT_MIN;
			end else begin
				mat_nx[l] = sval[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
		end else begin
			vld_s20 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		mat_s20  <= mat_nx;
		zero_s20 <= in_d.zero;
	end

	assign out_vld   = vld_s20;
	assign mat       = mat_s20;
	assign zero_norm = zero_s20;

endmodule
